// ===== hw/rtl/cdh_pkg.sv =====
// ----------------------------------------------------------------------------
// cdh_pkg: shared types and codes of the coverage depth histogram
// Command, status and register codes, the controller state type and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdh_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [1:0] CFG_MIN_DEPTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_DEPTH_STEP = 2'd2;
  localparam logic [1:0] CFG_TOP_BIN    = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RET_CHK,
    S_RET_WAIT,
    S_DIV,
    S_HIST_RD,
    S_HIST_WR,
    S_INC_CHK,
    S_INC_WR,
    S_OUT
  } cdh_state_t;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       setup_all;
    logic       setup_dist;
    logic       rd_depth;
    logic       ret_skip;
    logic       bin_start;
    logic       div_step;
    logic       bin_from_q;
    logic       hist_rd;
    logic       hist_wr;
    logic       ret_finish;
    logic       inc_setup;
    logic       inc_rd;
    logic       inc_wr;
    logic       qry_rd;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_hist;
    logic       out_load;
  } cdh_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] cmd;
    logic       len_zero;
    logic       unsorted;
    logic       too_long;
    logic       far;
    logic       cnt_zero;
    logic       depth_zero;
    logic       bin_direct;
    logic       div_done;
    logic       out_free;
  } cdh_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/coverage_depth_histogram_top.sv =====
// ----------------------------------------------------------------------------
// coverage_depth_histogram_top: pileup coverage depth histogram
// Keeps a ring of per-position depth counters, bins retired depths into a
// saturating histogram and answers bin queries.
//
// Use: items enter on the in_ channel (valid/ready) as a command with a read
// start, a read length and a bin index; every item gives exactly one beat on
// the out_ channel carrying a status and a bin count. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// One item is worked on at a time. A bin query, an unknown command, a
// zero-length add or a rejected add is decoded and its result loaded into
// the output register before the next item is taken. An accepted add first
// steps over the positions it retires: one with zero depth is read and
// skipped, a nonzero one below min or above max is binned directly, any
// other nonzero one is binned through the restoring divider (one quotient
// bit a cycle), and each bin is read and written back in the histogram.
// Then each covered position is read and written back in the depth RAM. A
// flush retires all WINDOW_SIZE slots in the same way. After reset both
// memories are swept clear, one entry a cycle, which keeps in_ready low
// until the sweep is done. The result sits in an output register, so a
// stalled receiver only holds the block once the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_depth_histogram_top #(
  parameter int WINDOW_SIZE = 512,
  parameter int MAX_BINS    = 1024,
  parameter int DEPTH_BITS  = 20,
  parameter int COUNT_BITS  = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [19:0]           cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_command,
  input  wire logic [30:0]           in_start_position,
  input  wire logic [15:0]           in_read_length,
  input  wire logic [9:0]            in_bin_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [COUNT_BITS-1:0]      out_bin_count
);

  // Command bundle from the sequencer and status bundle back to it.
  cdh_pkg::cdh_cmd_t cmd;
  cdh_pkg::cdh_sts_t sts;

  // The sequencer owns in_ready: it is high only while waiting for an item.
  cdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // The datapath holds all storage but the sequencer state, including the output register.
  cdh_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_BINS    (MAX_BINS),
    .DEPTH_BITS  (DEPTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_start_position (in_start_position),
    .in_read_length    (in_read_length),
    .in_bin_index      (in_bin_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_bin_count     (out_bin_count),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cdh_ram.sv =====
// ----------------------------------------------------------------------------
// cdh_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdh_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdh_ctrl: sequencing state machine
// Steps through memory clearing, retirement, binning, increment and
// histogram reads, and drives the datapath by command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cdh_pkg::cdh_sts_t sts_i,
  output cdh_pkg::cdh_cmd_t      cmd_o
);

  cdh_pkg::cdh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdh_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      cdh_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_nxt = cdh_pkg::S_IDLE;
        end
      end
      cdh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = cdh_pkg::S_DECODE;
        end
      end
      cdh_pkg::S_DECODE: begin
        unique case (sts_i.cmd)
          cdh_pkg::CMD_ADD: begin
            if (sts_i.len_zero) begin
              cmd_o.res_set = 1'b1;
              state_nxt     = cdh_pkg::S_OUT;
            end else if (sts_i.unsorted) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = cdh_pkg::ST_UNSORTED;
              state_nxt        = cdh_pkg::S_OUT;
            end else if (sts_i.too_long) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = cdh_pkg::ST_TOO_LONG;
              state_nxt        = cdh_pkg::S_OUT;
            end else if (sts_i.far) begin
              cmd_o.setup_all = 1'b1;
              state_nxt       = cdh_pkg::S_RET_CHK;
            end else begin
              cmd_o.setup_dist = 1'b1;
              state_nxt        = cdh_pkg::S_RET_CHK;
            end
          end
          cdh_pkg::CMD_FLUSH: begin
            cmd_o.setup_all = 1'b1;
            state_nxt       = cdh_pkg::S_RET_CHK;
          end
          cdh_pkg::CMD_READ: begin
            cmd_o.qry_rd   = 1'b1;
            cmd_o.res_set  = 1'b1;
            cmd_o.res_hist = 1'b1;
            state_nxt      = cdh_pkg::S_OUT;
          end
          default: begin
            cmd_o.res_set = 1'b1;
            state_nxt     = cdh_pkg::S_OUT;
          end
        endcase
      end
      cdh_pkg::S_RET_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.ret_finish = 1'b1;
          if (sts_i.cmd == cdh_pkg::CMD_FLUSH) begin
            cmd_o.res_set = 1'b1;
            state_nxt     = cdh_pkg::S_OUT;
          end else begin
            cmd_o.inc_setup = 1'b1;
            state_nxt       = cdh_pkg::S_INC_CHK;
          end
        end else begin
          cmd_o.rd_depth = 1'b1;
          state_nxt      = cdh_pkg::S_RET_WAIT;
        end
      end
      cdh_pkg::S_RET_WAIT: begin
        if (sts_i.depth_zero) begin
          cmd_o.ret_skip = 1'b1;
          state_nxt      = cdh_pkg::S_RET_CHK;
        end else begin
          cmd_o.bin_start = 1'b1;
          state_nxt = sts_i.bin_direct ? cdh_pkg::S_HIST_RD : cdh_pkg::S_DIV;
        end
      end
      cdh_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.bin_from_q = 1'b1;
          state_nxt        = cdh_pkg::S_HIST_RD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      cdh_pkg::S_HIST_RD: begin
        cmd_o.hist_rd = 1'b1;
        state_nxt     = cdh_pkg::S_HIST_WR;
      end
      cdh_pkg::S_HIST_WR: begin
        cmd_o.hist_wr = 1'b1;
        state_nxt     = cdh_pkg::S_RET_CHK;
      end
      cdh_pkg::S_INC_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.res_set = 1'b1;
          state_nxt     = cdh_pkg::S_OUT;
        end else begin
          cmd_o.inc_rd = 1'b1;
          state_nxt    = cdh_pkg::S_INC_WR;
        end
      end
      cdh_pkg::S_INC_WR: begin
        cmd_o.inc_wr = 1'b1;
        state_nxt    = cdh_pkg::S_INC_CHK;
      end
      cdh_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = cdh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdh_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdh_dp.sv =====
// ----------------------------------------------------------------------------
// cdh_dp: datapath of the coverage depth histogram
// Holds the item, configuration, window pointers, both memories, the bin
// divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdh_dp #(
  parameter int WINDOW_SIZE = 512,
  parameter int MAX_BINS    = 1024,
  parameter int DEPTH_BITS  = 20,
  parameter int COUNT_BITS  = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [19:0]       cfg_wdata,
  input  wire logic [1:0]        in_command,
  input  wire logic [30:0]       in_start_position,
  input  wire logic [15:0]       in_read_length,
  input  wire logic [9:0]        in_bin_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [COUNT_BITS-1:0]  out_bin_count,
  input  wire cdh_pkg::cdh_cmd_t cmd_i,
  output cdh_pkg::cdh_sts_t      sts_o
);

  localparam int WAW   = $clog2(WINDOW_SIZE);
  localparam int BAW   = $clog2(MAX_BINS);
  localparam int CW    = $clog2(WINDOW_SIZE + 1);
  localparam int DCW   = $clog2(DEPTH_BITS + 1);
  localparam int CLR_N = (WINDOW_SIZE > MAX_BINS) ? WINDOW_SIZE : MAX_BINS;
  localparam int CLW   = $clog2(CLR_N + 1);

  // Item and configuration
  logic [1:0]  cmd_r;
  logic [30:0] pos_r;
  logic [15:0] len_r;
  logic [9:0]  bidx_r;
  logic [19:0] min_r, max_r, step_r;
  logic [9:0]  top_r;

  // Window and loop state
  logic [WAW-1:0] wstart_r, ptr_r;
  logic [30:0]    base_r;
  logic           bvalid_r;
  logic [CW-1:0]  cnt_r;
  logic [CLW-1:0] clr_r;

  // Divider and bin
  logic [DEPTH_BITS-1:0] q_r;
  logic [19:0]           rem_r;
  logic [DCW-1:0]        dcnt_r;
  logic [BAW-1:0]        bin_r;

  // Result
  logic [1:0] res_status_r;
  logic       res_use_r;
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic [DEPTH_BITS-1:0] depth_rdata;
  logic [COUNT_BITS-1:0] hist_rdata;

  // Combinational helpers
  logic [31:0]           d32, diff32;
  logic [19:0]           step_eff;
  logic [20:0]           trial, divs;
  logic                  ge;
  logic [32:0]           bin_v, bin_a, bin_b;
  logic                  qry_ok;
  logic                  advance;
  logic [WAW-1:0]        ptr_inc;
  logic                  clr_dw, clr_hw;
  logic [DEPTH_BITS-1:0] depth_sat;
  logic [COUNT_BITS-1:0] hist_sat;
  logic                  d_we, h_we, h_re;
  logic [WAW-1:0]        d_waddr;
  logic [DEPTH_BITS-1:0] d_wdata;
  logic [BAW-1:0]        h_waddr, h_raddr;
  logic [COUNT_BITS-1:0] h_wdata;

  assign d32      = 32'(depth_rdata);
  assign diff32   = 32'(pos_r) - 32'(base_r);
  assign step_eff = (step_r == 20'd0) ? 20'd1 : step_r;
  assign trial    = {rem_r, q_r[DEPTH_BITS-1]};
  assign divs     = {1'b0, step_eff};
  assign ge       = (trial >= divs);
  assign qry_ok   = (32'(bidx_r) < 32'(MAX_BINS));
  assign advance  = cmd_i.hist_wr | cmd_i.ret_skip | cmd_i.inc_wr;
  assign ptr_inc  = (ptr_r == WAW'(WINDOW_SIZE - 1)) ? '0 : ptr_r + WAW'(1);
  assign clr_dw   = cmd_i.clr_step && (32'(clr_r) < 32'(WINDOW_SIZE));
  assign clr_hw   = cmd_i.clr_step && (32'(clr_r) < 32'(MAX_BINS));

  assign depth_sat = (depth_rdata == '1) ? depth_rdata : depth_rdata + DEPTH_BITS'(1);
  assign hist_sat  = (hist_rdata == '1) ? hist_rdata : hist_rdata + COUNT_BITS'(1);

  // Bin index: regular bins come from the quotient, the others directly.
  always_comb begin
    if (cmd_i.bin_from_q) begin
      bin_v = 33'(q_r) + 33'd1;
    end else if (d32 < 32'(min_r)) begin
      bin_v = 33'd0;
    end else begin
      bin_v = 33'(top_r);
    end
    bin_a = (bin_v > 33'(top_r)) ? 33'(top_r) : bin_v;
    bin_b = (bin_a > 33'(MAX_BINS - 1)) ? 33'(MAX_BINS - 1) : bin_a;
  end

  // Memory port selection
  assign d_we    = clr_dw | cmd_i.hist_wr | cmd_i.inc_wr;
  assign d_waddr = cmd_i.clr_step ? clr_r[WAW-1:0] : ptr_r;
  assign d_wdata = cmd_i.inc_wr ? depth_sat : '0;
  assign h_we    = clr_hw | cmd_i.hist_wr;
  assign h_waddr = cmd_i.clr_step ? clr_r[BAW-1:0] : bin_r;
  assign h_wdata = cmd_i.clr_step ? '0 : hist_sat;
  assign h_re    = cmd_i.hist_rd | cmd_i.qry_rd;
  assign h_raddr = cmd_i.qry_rd ? BAW'(bidx_r) : bin_r;

  cdh_ram #(.WIDTH(DEPTH_BITS), .DEPTH(WINDOW_SIZE)) u_depth_ram (
    .clk     (clk),
    .we      (d_we),
    .waddr   (d_waddr),
    .wdata   (d_wdata),
    .re      (cmd_i.rd_depth | cmd_i.inc_rd),
    .raddr   (ptr_r),
    .rdata_r (depth_rdata)
  );

  cdh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_hist_ram (
    .clk     (clk),
    .we      (h_we),
    .waddr   (h_waddr),
    .wdata   (h_wdata),
    .re      (h_re),
    .raddr   (h_raddr),
    .rdata_r (hist_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r  <= in_command;
      pos_r  <= in_start_position;
      len_r  <= in_read_length;
      bidx_r <= in_bin_index;
    end
    if (cmd_i.setup_all) begin
      ptr_r <= '0;
      cnt_r <= CW'(WINDOW_SIZE);
    end else if (cmd_i.setup_dist) begin
      ptr_r <= wstart_r;
      cnt_r <= CW'(diff32);
    end else if (cmd_i.inc_setup) begin
      cnt_r <= CW'(len_r);
    end else if (advance) begin
      ptr_r <= ptr_inc;
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd_i.bin_start) begin
      q_r    <= DEPTH_BITS'(d32 - 32'(min_r));
      rem_r  <= '0;
      dcnt_r <= DCW'(DEPTH_BITS);
    end else if (cmd_i.div_step) begin
      q_r    <= {q_r[DEPTH_BITS-2:0], ge};
      rem_r  <= ge ? 20'(trial - divs) : trial[19:0];
      dcnt_r <= dcnt_r - DCW'(1);
    end
    if (cmd_i.bin_start || cmd_i.bin_from_q) begin
      bin_r <= bin_b[BAW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_r <= cmd_i.res_status;
      res_use_r    <= cmd_i.res_hist & qry_ok;
    end
    if (cmd_i.out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= res_use_r ? hist_rdata : '0;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= 20'd1;
      max_r       <= 20'd1000;
      step_r      <= 20'd1;
      top_r       <= 10'd1001;
      wstart_r    <= '0;
      base_r      <= '0;
      bvalid_r    <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cdh_pkg::CFG_MIN_DEPTH:  min_r  <= cfg_wdata;
          cdh_pkg::CFG_MAX_DEPTH:  max_r  <= cfg_wdata;
          cdh_pkg::CFG_DEPTH_STEP: step_r <= cfg_wdata;
          cdh_pkg::CFG_TOP_BIN:    top_r  <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step && (clr_r != CLW'(CLR_N))) begin
        clr_r <= clr_r + CLW'(1);
      end
      if (cmd_i.ret_finish) begin
        wstart_r <= ptr_r;
        if (cmd_r == cdh_pkg::CMD_FLUSH) begin
          base_r   <= '0;
          bvalid_r <= 1'b0;
        end else begin
          base_r   <= pos_r;
          bvalid_r <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts_o.clr_done   = (clr_r == CLW'(CLR_N));
  assign sts_o.cmd        = cmd_r;
  assign sts_o.len_zero   = (len_r == 16'd0);
  assign sts_o.unsorted   = bvalid_r && (pos_r < base_r);
  assign sts_o.too_long   = (32'(len_r) > 32'(WINDOW_SIZE));
  assign sts_o.far        = !bvalid_r || (diff32 >= 32'(WINDOW_SIZE));
  assign sts_o.cnt_zero   = (cnt_r == '0);
  assign sts_o.depth_zero = (depth_rdata == '0);
  assign sts_o.bin_direct = (d32 < 32'(min_r)) || (d32 > 32'(max_r));
  assign sts_o.div_done   = (dcnt_r == '0);
  assign sts_o.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bin_count = out_count_r;

endmodule

`default_nettype wire

// ===== tb/coverage_depth_histogram_top_tb.sv =====
// ----------------------------------------------------------------------------
// coverage_depth_histogram_top_tb: self-checking bench for the depth histogram
// Drives add, flush, bin-query and unknown commands through the valid/ready
// input channel. An internal model of the depth ring and the histogram
// predicts every result beat, which is compared field by field. Random
// idling on both channels, and several register settings including the
// extremes, are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coverage_depth_histogram_top_tb;

  localparam int RING      = 512;
  localparam int NBINS     = 1024;
  localparam int DEPTH_W   = 20;
  localparam int COUNT_W   = 48;
  localparam int RAND_ITEMS = 1925;
  // Slowest single item is a flush or far jump over a full ring of nonzero
  // depths, each binned through the divider, plus the longest receiver stall.
  localparam int STALL_LIMIT = 60000;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = cdh_pkg::CFG_MIN_DEPTH;
  logic [19:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = cdh_pkg::CMD_ADD;
  logic [30:0] in_start_position = '0;
  logic [15:0] in_read_length = '0;
  logic [9:0] in_bin_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [COUNT_W-1:0] out_bin_count;

  coverage_depth_histogram_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_start_position(in_start_position),
    .in_read_length(in_read_length), .in_bin_index(in_bin_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_bin_count(out_bin_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } bin_result_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [30:0]        pos;
    logic [15:0]        len;
    logic [9:0]         bin;
    bit                 typed;   // expected beat written out below
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } stim_row_t;

  // Model state: the depth ring, its base and the histogram.
  logic [DEPTH_W-1:0] ring_depth [RING];
  logic [8:0]         ring_head;
  logic [30:0]        ring_base;
  bit                 base_known;
  logic [COUNT_W-1:0] depth_bins [NBINS];
  logic [19:0]        reg_min, reg_max, reg_step;
  logic [9:0]         reg_top;

  bin_result_t pending_results[$];
  int  fail_count = 0;
  bit  quiet = 1'b0;   // when set, neither side idles

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int bin_for_depth(input logic [DEPTH_W-1:0] d);
    int s, idx;
    s = (reg_step == 0) ? 1 : int'(reg_step);
    if (d < reg_min) idx = 0;
    else if (d > reg_max) idx = reg_top;
    else begin
      idx = 1 + (int'(d) - int'(reg_min)) / s;
      if (idx > reg_top) idx = reg_top;
    end
    if (idx >= NBINS) idx = NBINS - 1;
    return idx;
  endfunction

  // Bin a nonzero depth and clear its slot; counts saturate.
  function automatic void retire_slot(input int slot);
    int b;
    if (ring_depth[slot] == 0) return;
    b = bin_for_depth(ring_depth[slot]);
    if (depth_bins[b] != {COUNT_W{1'b1}}) depth_bins[b] = depth_bins[b] + 1;
    ring_depth[slot] = '0;
  endfunction

  function automatic void retire_ring();
    for (int i = 0; i < RING; i++) retire_slot(i);
    ring_head = '0;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < RING; i++) ring_depth[i] = '0;
    for (int i = 0; i < NBINS; i++) depth_bins[i] = '0;
    ring_head = '0;
    ring_base = '0;
    base_known = 1'b1;
    reg_min = 20'd1;
    reg_max = 20'd1000;
    reg_step = 20'd1;
    reg_top = 10'd1001;
  endfunction

  function automatic bin_result_t predict_coverage(input logic [1:0] cmd,
      input logic [30:0] pos, input logic [15:0] len, input logic [9:0] bin);
    bin_result_t r;
    int span_len, s;
    r.status = cdh_pkg::ST_OK;
    r.count = '0;
    if (cmd == cdh_pkg::CMD_ADD && len != 0) begin
      if (base_known && pos < ring_base) r.status = cdh_pkg::ST_UNSORTED;
      else if (len > RING) r.status = cdh_pkg::ST_TOO_LONG;
      else begin
        if (!base_known || (pos - ring_base) >= RING) retire_ring();
        else begin
          span_len = int'(pos - ring_base);
          for (int k = 0; k < span_len; k++) retire_slot((int'(ring_head) + k) % RING);
          ring_head = 9'((int'(ring_head) + span_len) % RING);
        end
        ring_base = pos;
        base_known = 1'b1;
        for (int k = 0; k < int'(len); k++) begin
          s = (int'(ring_head) + k) % RING;
          if (ring_depth[s] != {DEPTH_W{1'b1}}) ring_depth[s] = ring_depth[s] + 1;
        end
      end
    end else if (cmd == cdh_pkg::CMD_FLUSH) begin
      retire_ring();
      ring_base = '0;
      base_known = 1'b0;
    end else if (cmd == cdh_pkg::CMD_READ) begin
      r.count = depth_bins[bin];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat, wait for the handshake, then record what should come back.
  task automatic send_beat(input stim_row_t row);
    bin_result_t want;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= row.cmd;
    in_start_position <= row.pos;
    in_read_length <= row.len;
    in_bin_index <= row.bin;
    do @(posedge clk); while (!in_ready);
    want = predict_coverage(row.cmd, row.pos, row.len, row.bin);
    if (row.typed) begin
      want.status = row.status;
      want.count = row.count;
    end
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  // Let everything drain, so the block is idle before a register write.
  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      cdh_pkg::CFG_MIN_DEPTH:  reg_min = val;
      cdh_pkg::CFG_MAX_DEPTH:  reg_max = val;
      cdh_pkg::CFG_DEPTH_STEP: reg_step = val;
      default:                 reg_top = val[9:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [19:0] mn, input logic [19:0] mx,
                              input logic [19:0] st, input logic [9:0] tp);
    wait_drained();
    write_reg(cdh_pkg::CFG_MIN_DEPTH, mn);
    write_reg(cdh_pkg::CFG_MAX_DEPTH, mx);
    write_reg(cdh_pkg::CFG_DEPTH_STEP, st);
    write_reg(cdh_pkg::CFG_TOP_BIN, {10'd0, tp});
  endtask

  function automatic stim_row_t make_row(input logic [1:0] c, input logic [30:0] p,
                                         input logic [15:0] l, input logic [9:0] b);
    stim_row_t r;
    r.cmd = c; r.pos = p; r.len = l; r.bin = b;
    r.typed = 1'b0; r.status = cdh_pkg::ST_OK; r.count = '0;
    return r;
  endfunction

  // One random beat. Most are sorted adds close to the current base, so the
  // ring keeps retiring real depths; the rest are queries, flushes, far adds and broken input.
  function automatic stim_row_t random_row();
    int r, l;
    logic [30:0] p;
    r = $urandom_range(0, 99);
    l = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 40) :
        (($urandom_range(0, 9) == 0) ? $urandom_range(300, RING) :
                                        $urandom_range(41, 160));
    p = base_known ? ring_base : 31'($urandom_range(0, 32'h7FF0_0000));
    if (base_known && ring_base > 31'h7FFF_0000)
      return make_row(cdh_pkg::CMD_FLUSH, 31'($urandom()), 16'($urandom()),
                      10'($urandom()));
    if (r < 68) begin
      if ($urandom_range(0, 49) == 0) p = p + 31'($urandom_range(RING, 5000));
      else if (base_known) p = p + 31'($urandom_range(0, 20));
      return make_row(cdh_pkg::CMD_ADD, p, 16'(l), 10'($urandom()));
    end
    if (r < 80) begin
      return make_row(cdh_pkg::CMD_READ, 31'($urandom()), 16'($urandom()),
                      ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 24)) :
                                                   10'($urandom()));
    end
    if (r < 84 && base_known && ring_base > 0)
      return make_row(cdh_pkg::CMD_ADD, 31'($urandom_range(0, int'(ring_base) - 1)),
                      16'($urandom_range(1, 65535)), 10'($urandom()));
    if (r < 88)
      return make_row(cdh_pkg::CMD_ADD, p, 16'($urandom_range(RING + 1, 65535)),
                      10'($urandom()));
    if (r < 90)
      return make_row(cdh_pkg::CMD_ADD, 31'($urandom()), 16'd0, 10'($urandom()));
    if (r < 92)
      return make_row(CMD_UNKNOWN, 31'($urandom()), 16'($urandom()), 10'($urandom()));
    if (r < 94)
      return make_row(cdh_pkg::CMD_FLUSH, 31'($urandom()), 16'($urandom()),
                      10'($urandom()));
    return make_row(cdh_pkg::CMD_ADD,
                    base_known ? p + 31'($urandom_range(0, 1 << 16)) : p,
                    16'($urandom_range(1, 64)), 10'($urandom()));
  endfunction

  // Directed rows: fixed answers only where they are obvious (a clear
  // histogram after reset, error codes, no-ops); the rest go to the model.
  stim_row_t directed_rows[$];

  task automatic add_typed(input logic [1:0] c, input logic [30:0] p, input logic [15:0] l,
                           input logic [9:0] b, input logic [1:0] st);
    stim_row_t r;
    r = make_row(c, p, l, b);
    r.typed = 1'b1;
    r.status = st;
    directed_rows.push_back(r);
  endtask

  task automatic build_directed();
    add_typed(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd0, cdh_pkg::ST_OK);   // empty histogram
    add_typed(cdh_pkg::CMD_READ, 31'h7FFF_FFFF, 16'hFFFF, 10'd1023, cdh_pkg::ST_OK);
    add_typed(cdh_pkg::CMD_ADD, 31'd7, 16'd0, 10'd0, cdh_pkg::ST_OK);    // zero length
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd100, 16'd10, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd100, 16'd10, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd104, 16'd3, 10'd0));
    // behind the base
    add_typed(cdh_pkg::CMD_ADD, 31'd50, 16'd4, 10'd0, cdh_pkg::ST_UNSORTED);
    // unsorted wins over too long
    add_typed(cdh_pkg::CMD_ADD, 31'd50, 16'd600, 10'd0, cdh_pkg::ST_UNSORTED);
    add_typed(cdh_pkg::CMD_ADD, 31'd104, 16'd513, 10'd0, cdh_pkg::ST_TOO_LONG);
    add_typed(cdh_pkg::CMD_ADD, 31'd104, 16'hFFFF, 10'd0, cdh_pkg::ST_TOO_LONG);
    // full ring, then a far jump
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd110, 16'd512, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd2000, 16'd1, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd1));
    directed_rows.push_back(make_row(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd2));
    directed_rows.push_back(make_row(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd3));
    add_typed(CMD_UNKNOWN, 31'h7FFF_FFFF, 16'hFFFF, 10'h3FF, cdh_pkg::ST_OK);
    directed_rows.push_back(make_row(cdh_pkg::CMD_FLUSH, 31'd0, 16'd0, 10'd0));
    // after flush
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'd5, 16'd2, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_FLUSH, 31'h7FFF_FFFF, 16'hFFFF, 10'h3FF));
    // top coordinate
    directed_rows.push_back(make_row(cdh_pkg::CMD_ADD, 31'h7FFF_FFFF, 16'd1, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_FLUSH, 31'd0, 16'd0, 10'd0));
    directed_rows.push_back(make_row(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd1));
    directed_rows.push_back(make_row(cdh_pkg::CMD_READ, 31'd0, 16'd0, 10'd0));
  endtask

  // Receiver: stalls of random length, dropped entirely while quiet is set.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", {62'd0, out_status}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_bin_count !== want.count)
          report_mismatch("bin_count", out_bin_count, want.count);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_reset();
    build_directed();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Settings change between phases, once the block has gone idle.
      case (i)
        300:  load_setting(20'd0, 20'hFFFFF, 20'hFFFFF, 10'd1023);
        600:  load_setting(20'd3, 20'd20, 20'd0, 10'd2);
        900:  load_setting(20'd1, 20'd40, 20'd3, 10'd10);
        1200: load_setting(20'hFFFFF, 20'd0, 20'd1, 10'd1023);
        1500: load_setting(20'($urandom_range(0, 4)), 20'($urandom_range(5, 60)),
                           20'($urandom_range(1, 7)), 10'($urandom_range(2, 1023)));
        1750: load_setting(20'd1, 20'd1000, 20'd1, 10'd1001);
        default: ;
      endcase
      if (i == 1000) wait_drained();   // sender holds off until all results are in
      quiet = (i >= 400 && i < 520) || (i >= 1600 && i < 1680);
      send_beat(random_row());
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cdh_pkg.sv
hw/rtl/cdh_ram.sv
hw/rtl/cdh_ctrl.sv
hw/rtl/cdh_dp.sv
hw/rtl/coverage_depth_histogram_top.sv
tb/coverage_depth_histogram_top_tb.sv
